// ===== sv/sha256_counter_keystream_xor_macros.svh =====
// Assertion macros shared by the checker
`ifndef SHA256_COUNTER_KEYSTREAM_XOR_MACROS_SVH
`define SHA256_COUNTER_KEYSTREAM_XOR_MACROS_SVH
// implication checked on every clock, off during reset
`define SKX_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
// next-cycle implication
`define SKX_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

// ===== sv/skx_pkg.sv =====
// ----------------------------------------------------------------------------
// skx_pkg
// Types, constants and round functions for the SHA-256 keystream block.
// ----------------------------------------------------------------------------
package skx_pkg;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY0 = 3'd0, REG_KEY1 = 3'd1, REG_KEY2 = 3'd2,
        REG_KEY3 = 3'd3, REG_NONCE_HI = 3'd4, REG_NONCE_LO = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {ST_IDLE, ST_HASH, ST_FINAL, ST_OUT} t_state;

    // word handed from the front to the back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       need_hash;
        logic [4:0] offset;
        logic [31:0] counter;
    } t_word;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [31:0] LEN_WORD = 32'd416;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[t];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ===== sv/skx_front.sv =====
// ----------------------------------------------------------------------------
// skx_front
// Accepts input words, tracks offset and counter, queues classified words.
// ----------------------------------------------------------------------------
module skx_front #(
    parameter int DEPTH = skx_pkg::FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_message,
    output logic           o_q_valid,
    output skx_pkg::t_word o_q_word,
    input  logic           i_q_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    skx_pkg::t_word r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic [4:0]     r_offset;
    logic [31:0]    r_counter;
    logic           push;

    assign o_ready   = (r_cnt != (AW+1)'(DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_word  = r_mem[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{data: i_data_byte, last: i_end_of_message,
                             need_hash: (r_offset == 5'd0), offset: r_offset,
                             counter: r_counter};
        end
    end

    // pointers, offset and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
            r_offset <= '0; r_counter <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
                if (i_end_of_message) begin
                    r_offset <= '0; r_counter <= '0;
                end else begin
                    r_offset <= r_offset + 5'd1;
                    if (r_offset == 5'd31) r_counter <= r_counter + 32'd1;
                end
            end
            if (i_q_pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(i_q_pop);
        end
    end
endmodule

// ===== sv/skx_back.sv =====
// ----------------------------------------------------------------------------
// skx_back
// Runs one SHA-256 round per cycle at block start and XORs bytes out.
// ----------------------------------------------------------------------------
module skx_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [5:0][63:0] i_cfg,
    input  logic           i_q_valid,
    input  skx_pkg::t_word i_q_word,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last
);
    skx_pkg::t_state r_state, n_state;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_ks [8];
    logic [5:0]  r_t;
    logic [7:0]  r_out;
    logic        r_last;
    logic [31:0] s0, s1, ch, mj, t1, t2, w, a15, a2;
    logic [31:0] ksw;
    logic [31:0] h0;

    // round datapath: window slot 0 holds w[t]
    always_comb begin
        a15 = r_w[1];
        a2  = r_w[14];
        w   = r_w[0] + (skx_pkg::rotr(a15,7) ^ skx_pkg::rotr(a15,18) ^ (a15 >> 3))
            + r_w[9] + (skx_pkg::rotr(a2,17) ^ skx_pkg::rotr(a2,19) ^ (a2 >> 10));
        s1 = skx_pkg::rotr(r_v[4],6) ^ skx_pkg::rotr(r_v[4],11) ^ skx_pkg::rotr(r_v[4],25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + s1 + ch + skx_pkg::round_k(r_t) + r_w[0];
        s0 = skx_pkg::rotr(r_v[0],2) ^ skx_pkg::rotr(r_v[0],13) ^ skx_pkg::rotr(r_v[0],22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = s0 + mj;
        ksw = r_ks[i_q_word.offset[4:2]];
        // first digest word, its top byte serves offset 0
        h0  = r_v[0] + skx_pkg::init_h(3'd0);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            skx_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_word.need_hash) n_state = skx_pkg::ST_HASH;
                    else begin n_state = skx_pkg::ST_OUT; o_q_pop = 1'b1; end
                end
            end
            skx_pkg::ST_HASH:  if (r_t == 6'd63) n_state = skx_pkg::ST_FINAL;
            skx_pkg::ST_FINAL: begin n_state = skx_pkg::ST_OUT; o_q_pop = 1'b1; end
            skx_pkg::ST_OUT:   if (i_ready) n_state = skx_pkg::ST_IDLE;
            default:           n_state = skx_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= skx_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            skx_pkg::ST_IDLE: begin
                r_t <= '0;
                for (int i = 0; i < 6; i++) begin
                    r_w[2*i]   <= i_cfg[i][63:32];
                    r_w[2*i+1] <= i_cfg[i][31:0];
                end
                r_w[12] <= i_q_word.counter;
                r_w[13] <= skx_pkg::PAD_WORD;
                r_w[14] <= '0;
                r_w[15] <= skx_pkg::LEN_WORD;
                for (int i = 0; i < 8; i++) r_v[i] <= skx_pkg::init_h(3'(i));
                if (i_q_valid && !i_q_word.need_hash) begin
                    r_out  <= i_q_word.data ^ ksw[8*(3-i_q_word.offset[1:0]) +: 8];
                    r_last <= i_q_word.last;
                end
            end
            skx_pkg::ST_HASH: begin
                r_t <= r_t + 6'd1;
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            skx_pkg::ST_FINAL: begin
                for (int i = 0; i < 8; i++) r_ks[i] <= r_v[i] + skx_pkg::init_h(3'(i));
                r_out  <= i_q_word.data ^ h0[31:24];
                r_last <= i_q_word.last;
            end
            default: ;
        endcase
    end

    assign o_valid    = (r_state == skx_pkg::ST_OUT);
    assign o_out_byte = r_out;
    assign o_out_last = r_last;
endmodule

// ===== sv/sha256_counter_keystream_xor.sv =====
// ----------------------------------------------------------------------------
// sha256_counter_keystream_xor
// SHA-256 counter-mode keystream XOR, one byte per word.
// ----------------------------------------------------------------------------
// channel  signals                        direction
// input    i_valid/o_ready, data, eom     in
// output   o_valid/i_ready, byte, last    out
// config   i_cfg_we, i_cfg_idx, i_cfg_data in
// A byte at block offset 0 goes through load, 64 rounds in the shared round
// unit, finalize and output; other bytes go from load straight to output.
// A two-word queue lets input be taken while the round unit is busy.
// Synchronous active-low reset clears counter, offset, queue and sequencer.
module sha256_counter_keystream_xor #(
    parameter int FIFO_DEPTH = skx_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        i_cfg_we,
    input  logic [skx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [skx_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    logic [5:0][63:0] r_cfg;
    logic             q_valid, q_pop;
    skx_pkg::t_word   q_word;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= '0;
        else if (i_cfg_we && i_cfg_idx <= skx_pkg::REG_NONCE_LO) r_cfg[i_cfg_idx] <= i_cfg_data;
    end

    skx_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_byte, .i_end_of_message,
        .o_q_valid(q_valid), .o_q_word(q_word), .i_q_pop(q_pop)
    );

    skx_back u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg), .i_q_valid(q_valid), .i_q_word(q_word),
        .o_q_pop(q_pop), .o_valid, .i_ready, .o_out_byte, .o_out_last
    );
endmodule

// ===== sv/skx_checker.sv =====
// ----------------------------------------------------------------------------
// skx_checker
// Port-level checks on the keystream block.
// ----------------------------------------------------------------------------
`include "sha256_counter_keystream_xor_macros.svh"
module skx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);
    `SKX_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out_byte))
    `SKX_ASSERT_NXT(a_gap, i_clk, i_rst_n, o_valid && i_ready, !o_valid)
    `SKX_ASSERT_NXT(a_last, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_out_last))
endmodule

bind sha256_counter_keystream_xor skx_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_out_byte, .o_out_last
);

// ===== tb/tb_sha256_counter_keystream_xor.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_counter_keystream_xor
// Self-checking bench for the SHA-256 counter-mode keystream XOR block.
// Bytes go in over a valid/ready channel in bursts, and the output side
// stalls at random. A SHA-256 predictor builds each 32-byte keystream block
// from the mirrored key, nonce and block counter. Every output word is
// compared with the oldest prediction. Key and nonce are reloaded between
// phases while the block is idle; messages run across phase edges, so a
// reload can fall mid-block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sha256_counter_keystream_xor;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 210;
    localparam logic [skx_pkg::CFG_IDX_W-1:0] IDX_SPARE6 = 3'd6;
    localparam logic [skx_pkg::CFG_IDX_W-1:0] IDX_SPARE7 = 3'd7;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

    typedef struct {
        logic [7:0] out_byte;
        logic       out_last;
    } t_xor_result;

    typedef struct {
        logic [7:0] data;
        logic       eom;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_end_of_message;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        i_cfg_we;
    logic [skx_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [skx_pkg::CFG_DATA_W-1:0] i_cfg_data;

    // mirrored registers and keystream state
    logic [63:0]  cfg_mirror [6];
    logic [31:0]  blk_counter;
    logic [4:0]   blk_offset;
    logic [255:0] ks_block;

    t_xor_result expected_words [$];
    int          err_count;
    int          idle_cycles;
    int          burst_left;
    int          msg_left;
    bit          hold_rx;

    sha256_counter_keystream_xor u_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // SHA-256 of key | nonce | counter as a single padded block
    function automatic logic [255:0] keystream_digest(input logic [31:0] ctr);
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, s0, s1, ch, mj, t1, t2;
        logic [255:0] dig;
        for (int i = 0; i < 6; i++) begin
            w[2*i]   = cfg_mirror[i][63:32];
            w[2*i+1] = cfg_mirror[i][31:0];
        end
        w[12] = ctr;
        w[13] = 32'h8000_0000;
        w[14] = 32'd0;
        w[15] = 32'd416;
        for (int i = 0; i < 8; i++) v[i] = IV[i];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                s0 = ror32(w[(t-15)%16], 7) ^ ror32(w[(t-15)%16], 18) ^ (w[(t-15)%16] >> 3);
                s1 = ror32(w[(t-2)%16], 17) ^ ror32(w[(t-2)%16], 19) ^ (w[(t-2)%16] >> 10);
                wt = w[t%16] + s0 + w[(t-7)%16] + s1;
                w[t%16] = wt;
            end
            s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
            ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
            t1 = v[7] + s1 + ch + RK[t] + wt;
            s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
            mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t2 = s0 + mj;
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) dig[255-32*i -: 32] = IV[i] + v[i];
        return dig;
    endfunction

    // predict one output word and advance offset/counter
    function automatic t_xor_result predict_xor(input logic [7:0] d, input logic eom);
        t_xor_result r;
        if (blk_offset == 5'd0) ks_block = keystream_digest(blk_counter);
        r.out_byte = d ^ ks_block[255-8*blk_offset -: 8];
        r.out_last = eom;
        if (eom) begin
            blk_counter = 32'd0;
            blk_offset = 5'd0;
        end else begin
            blk_offset = blk_offset + 5'd1;
            if (blk_offset == 5'd0) blk_counter = blk_counter + 32'd1;
        end
        return r;
    endfunction

    // input acceptance -> prediction
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            expected_words.push_back(predict_xor(i_data_byte, i_end_of_message));
    end

    // output check
    always @(posedge i_clk) begin
        t_xor_result exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected output word: byte %h last %b", o_out_byte, o_out_last);
                err_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (o_out_byte !== exp_w.out_byte) begin
                    $error("out_byte expected %h actual %h", exp_w.out_byte, o_out_byte);
                    err_count++;
                end
                if (o_out_last !== exp_w.out_last) begin
                    $error("out_last expected %b actual %b", exp_w.out_last, o_out_last);
                    err_count++;
                end
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int mode;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_rx) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end else begin
                mode = $urandom_range(0, 2);
                repeat ($urandom_range(20, 150)) begin
                    case (mode)
                        0: i_ready <= 1'b1;
                        1: i_ready <= 1'($urandom_range(0, 1));
                        default: i_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge i_clk);
                    if (hold_rx) break;
                end
            end
        end
    end

    // one register write; caller lowers the enable when done
    task automatic write_reg(input logic [skx_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        if (idx <= skx_pkg::REG_NONCE_LO) cfg_mirror[idx] = val;
        @(posedge i_clk);
    endtask

    // send one word, with an optional idle gap between bursts
    task automatic send_byte(input logic [7:0] d, input logic eom);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data_byte <= d;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        wait (expected_words.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // directed rows: byte extremes, single-byte messages, end of message
    // mid-block, and a block left open at the end
    t_stim_row dir_rows [25] = '{
        '{8'h00, 1'b1}, '{8'hff, 1'b1}, '{8'h00, 1'b0}, '{8'hff, 1'b0},
        '{8'h01, 1'b0}, '{8'h80, 1'b0}, '{8'h7f, 1'b1}, '{8'h55, 1'b0},
        '{8'haa, 1'b0}, '{8'h00, 1'b0}, '{8'hff, 1'b0}, '{8'h0f, 1'b0},
        '{8'hf0, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
        '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
        '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0}, '{8'h00, 1'b0},
        '{8'h3c, 1'b0}};

    initial begin
        int len;
        logic [63:0] v;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = 8'h00;
        i_end_of_message = 1'b0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        hold_rx = 1'b0;
        err_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        msg_left = 0;
        for (int i = 0; i < 6; i++) cfg_mirror[i] = 64'd0;
        blk_counter = 32'd0;
        blk_offset = 5'd0;
        ks_block = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset key; the last row leaves a block open
        foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].eom);
        // run past the end of the first block so the counter steps
        for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        drain();

        // random phases, reconfigured mid-message while idle
        for (int ph = 0; ph < PHASES; ph++) begin
            for (int r = skx_pkg::REG_KEY0; r <= skx_pkg::REG_NONCE_LO; r++) begin
                case (ph)
                    0: v = '1;
                    1: v = '0;
                    2: v = 64'haaaa_aaaa_aaaa_aaaa;
                    default: v = {32'($urandom), 32'($urandom)};
                endcase
                // later phases touch only some registers
                if (ph < 3 || $urandom_range(0, 1)) write_reg(skx_pkg::t_reg_idx'(r), v);
            end
            // spare indexes must be ignored
            write_reg(IDX_SPARE6, {32'($urandom), 32'($urandom)});
            write_reg(IDX_SPARE7, '1);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            if (ph == 3) hold_rx = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (msg_left == 0) begin
                    len = $urandom_range(0, 19);
                    msg_left = (len < 14) ? $urandom_range(1, 40) :
                               (len < 19) ? $urandom_range(41, 100) :
                                            $urandom_range(101, 300);
                end
                send_byte(8'($urandom_range(0, 255)), msg_left == 1);
                msg_left--;
            end
            drain();
        end

        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sha256_counter_keystream_xor.f =====
+incdir+sv
sv/skx_pkg.sv
sv/skx_front.sv
sv/skx_back.sv
sv/sha256_counter_keystream_xor.sv
sv/skx_checker.sv
tb/tb_sha256_counter_keystream_xor.sv
